/* sv/sdsi_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sdsi_pkg;

    typedef enum logic [13:0] {
        S_IDLE     = 14'b00000000000001,
        S_CMD0     = 14'b00000000000010,
        S_CMD8     = 14'b00000000000100,
        S_OCR1     = 14'b00000000001000,
        S_CMD55    = 14'b00000000010000,
        S_ACMD41   = 14'b00000000100000,
        S_OCR2     = 14'b00000001000000,
        S_CMD59    = 14'b00000010000000,
        S_CMD16    = 14'b00000100000000,
        S_READY    = 14'b00001000000000,
        S_FAIL_R7  = 14'b00010000000000,
        S_FAIL_OCR = 14'b00100000000000,
        S_FAIL_PWR = 14'b01000000000000,
        S_ACCESS   = 14'b10000000000000
    } step_t;

    localparam logic [1:0] REQ_START  = 2'd0;
    localparam logic [1:0] REQ_RESP   = 2'd1;
    localparam logic [1:0] REQ_ACCESS = 2'd2;

    localparam logic [2:0] ACC_RD_SINGLE = 3'd0;
    localparam logic [2:0] ACC_RD_MULTI  = 3'd1;
    localparam logic [2:0] ACC_WR_SINGLE = 3'd2;
    localparam logic [2:0] ACC_WR_MULTI  = 3'd3;
    localparam logic [2:0] ACC_STOP      = 3'd4;

    localparam logic [2:0] KIND_UNKNOWN  = 3'd0;
    localparam logic [2:0] KIND_V1       = 3'd1;
    localparam logic [2:0] KIND_SDSC     = 3'd2;
    localparam logic [2:0] KIND_SDHC     = 3'd3;
    localparam logic [2:0] KIND_UNUSABLE = 3'd4;

    localparam logic [2:0] STAT_BUSY     = 3'd0;
    localparam logic [2:0] STAT_READY    = 3'd1;
    localparam logic [2:0] STAT_BAD_R7   = 3'd2;
    localparam logic [2:0] STAT_BAD_OCR  = 3'd3;
    localparam logic [2:0] STAT_NO_POWER = 3'd4;
    localparam logic [2:0] STAT_REFUSED  = 3'd5;
    localparam logic [2:0] STAT_CARD_ERR = 3'd6;
    localparam logic [2:0] STAT_ACC_OK   = 3'd7;

    localparam logic [5:0] CMD_GO_IDLE   = 6'd0;
    localparam logic [5:0] CMD_IF_COND   = 6'd8;
    localparam logic [5:0] CMD_STOP      = 6'd12;
    localparam logic [5:0] CMD_SET_BLEN  = 6'd16;
    localparam logic [5:0] CMD_RD_SINGLE = 6'd17;
    localparam logic [5:0] CMD_RD_MULTI  = 6'd18;
    localparam logic [5:0] CMD_WR_SINGLE = 6'd24;
    localparam logic [5:0] CMD_WR_MULTI  = 6'd25;
    localparam logic [5:0] CMD_OP_COND   = 6'd41;
    localparam logic [5:0] CMD_APP       = 6'd55;
    localparam logic [5:0] CMD_READ_OCR  = 6'd58;
    localparam logic [5:0] CMD_CRC_ON    = 6'd59;

    localparam logic [7:0]  CRC_CMD0     = 8'h95;
    localparam logic [7:0]  CRC_CMD8     = 8'h87;
    localparam logic [7:0]  CRC_NONE     = 8'hFF;
    localparam logic [31:0] ARG_IF_COND  = 32'h0000_01AA;
    localparam logic [31:0] ARG_HCS      = 32'h4000_0000;
    localparam logic [31:0] SECTOR_BYTES = 32'd512;
    localparam logic [7:0]  R7_PATTERN   = 8'hAA;
    localparam logic [3:0]  R7_VHS_OK    = 4'd1;
    localparam logic [7:0]  R1_IDLE      = 8'h01;
    localparam logic [7:0]  R1_OK        = 8'h00;
    localparam int          SECTOR_SHIFT = 9;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  resp_r1;
        logic [31:0] resp_tail;
        logic [2:0]  access_kind;
        logic [31:0] sector;
    } item_t;

    typedef struct packed {
        logic        cmd_valid;
        logic        wake_clocks;
        logic [5:0]  cmd_index;
        logic [31:0] cmd_arg;
        logic [7:0]  cmd_crc;
        logic [2:0]  card_type;
        logic [2:0]  status;
    } result_t;

    function automatic logic [2:0] standing(input step_t step);
        logic [2:0] st;
        case (step)
            S_IDLE:     st = STAT_REFUSED;
            S_READY:    st = STAT_READY;
            S_FAIL_R7:  st = STAT_BAD_R7;
            S_FAIL_OCR: st = STAT_BAD_OCR;
            S_FAIL_PWR: st = STAT_NO_POWER;
            default:    st = STAT_BUSY;
        endcase
        return st;
    endfunction

    function automatic logic [5:0] access_cmd(input logic [2:0] kind);
        logic [5:0] idx;
        case (kind)
            ACC_RD_SINGLE: idx = CMD_RD_SINGLE;
            ACC_RD_MULTI:  idx = CMD_RD_MULTI;
            ACC_WR_SINGLE: idx = CMD_WR_SINGLE;
            ACC_WR_MULTI:  idx = CMD_WR_MULTI;
            default:       idx = CMD_STOP;
        endcase
        return idx;
    endfunction

endpackage

`default_nettype wire

/* sv/sd_spi_init_and_access_sequencer_unit.sv */
// SD card SPI-mode command sequencer.
// Input channel (in_valid/in_stall): one word per request: start, card
// response (R1 plus 32-bit tail) or block access (kind, sector).
// Output channel (out_valid/out_stall): exactly one word per request, giving
// the command frame to send (cmd_valid, wake_clocks, index, argument, CRC),
// the recorded card type and a status code.
// Path: a word accepted into the input register is evaluated there and
// placed in the output register when out_stall does not hold a word there.
// Throughput: one word per cycle unless out_stall holds the output word; the
// sequencer state updates in the same cycle the word goes from input to output.
// Reset: sequencer idle, card type unknown, both registers empty.
// Stall: while out_stall holds a word in the output register, a word in
// the input register waits and in_stall rises; with the input register
// empty one further word is still taken.
`timescale 1ns / 1ps
`default_nettype none

module sd_spi_init_and_access_sequencer_unit
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  req_type,
    input  wire logic [7:0]  resp_r1,
    input  wire logic [31:0] resp_tail,
    input  wire logic [2:0]  access_kind,
    input  wire logic [31:0] sector,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             cmd_valid,
    output logic             wake_clocks,
    output logic [5:0]       cmd_index,
    output logic [31:0]      cmd_arg,
    output logic [7:0]       cmd_crc,
    output logic [2:0]       card_type,
    output logic [2:0]       status
);

    sdsi_pkg::item_t   item_in;
    sdsi_pkg::item_t   item;
    sdsi_pkg::result_t res;
    sdsi_pkg::result_t res_reg;
    logic              item_valid;
    logic              out_blocked;
    logic              advance;
    logic              out_valid_reg;

    assign item_in.req_type    = req_type;
    assign item_in.resp_r1     = resp_r1;
    assign item_in.resp_tail   = resp_tail;
    assign item_in.access_kind = access_kind;
    assign item_in.sector      = sector;

    assign out_blocked = out_valid_reg && out_stall;
    assign advance     = item_valid && !out_blocked;

    sdsi_in_stage u_in_stage
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .item_in     (item_in),
        .out_blocked (out_blocked),
        .item_valid  (item_valid),
        .item_out    (item)
    );

    sdsi_seq_core u_seq_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item),
        .res     (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_blocked)
        begin
            out_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign cmd_valid   = res_reg.cmd_valid;
    assign wake_clocks = res_reg.wake_clocks;
    assign cmd_index   = res_reg.cmd_index;
    assign cmd_arg     = res_reg.cmd_arg;
    assign cmd_crc     = res_reg.cmd_crc;
    assign card_type   = res_reg.card_type;
    assign status      = res_reg.status;

endmodule

`default_nettype wire

/* sv/sdsi_in_stage.sv */
`timescale 1ns / 1ps
`default_nettype none

module sdsi_in_stage
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire sdsi_pkg::item_t item_in,
    input  wire logic           out_blocked,
    output logic                item_valid,
    output sdsi_pkg::item_t     item_out
);

    logic            valid_reg;
    logic            valid_next;
    sdsi_pkg::item_t item_reg;

    assign in_stall   = valid_reg && out_blocked;
    assign valid_next = in_stall ? 1'b1 : in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            item_reg <= item_in;
        end
    end

    assign item_valid = valid_reg;
    assign item_out   = item_reg;

endmodule

`default_nettype wire

/* sv/sdsi_seq_core.sv */
`timescale 1ns / 1ps
`default_nettype none

module sdsi_seq_core
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            advance,
    input  wire sdsi_pkg::item_t item,
    output sdsi_pkg::result_t    res
);

    sdsi_pkg::step_t step_reg;
    sdsi_pkg::step_t step_next;
    logic [2:0]      kind_reg;
    logic [2:0]      kind_next;
    logic            cmd_valid;
    logic            wake;
    logic [5:0]      cmd_index;
    logic [31:0]     cmd_arg;
    logic [7:0]      cmd_crc;
    logic [2:0]      status;
    logic [31:0]     acc_arg;

    always_comb
    begin
        step_next = step_reg;
        kind_next = kind_reg;
        cmd_valid = 1'b0;
        wake      = 1'b0;
        cmd_index = '0;
        cmd_arg   = '0;
        cmd_crc   = '0;
        status    = sdsi_pkg::STAT_BUSY;
        acc_arg   = '0;
        case (item.req_type)
            sdsi_pkg::REQ_START:
            begin
                kind_next = sdsi_pkg::KIND_UNKNOWN;
                wake      = 1'b1;
                cmd_valid = 1'b1;
                cmd_index = sdsi_pkg::CMD_GO_IDLE;
                cmd_crc   = sdsi_pkg::CRC_CMD0;
                step_next = sdsi_pkg::S_CMD0;
            end
            sdsi_pkg::REQ_RESP:
            begin
                case (step_reg)
                    sdsi_pkg::S_CMD0:
                    begin
                        cmd_valid = 1'b1;
                        if (item.resp_r1 == sdsi_pkg::R1_IDLE)
                        begin
                            cmd_index = sdsi_pkg::CMD_IF_COND;
                            cmd_arg   = sdsi_pkg::ARG_IF_COND;
                            cmd_crc   = sdsi_pkg::CRC_CMD8;
                            step_next = sdsi_pkg::S_CMD8;
                        end
                        else
                        begin
                            cmd_index = sdsi_pkg::CMD_GO_IDLE;
                            cmd_crc   = sdsi_pkg::CRC_CMD0;
                        end
                    end
                    sdsi_pkg::S_CMD8:
                    begin
                        if (item.resp_r1[2])
                        begin
                            kind_next = sdsi_pkg::KIND_V1;
                            cmd_valid = 1'b1;
                            cmd_index = sdsi_pkg::CMD_READ_OCR;
                            cmd_crc   = sdsi_pkg::CRC_NONE;
                            step_next = sdsi_pkg::S_OCR1;
                        end
                        else if (item.resp_tail[7:0] != sdsi_pkg::R7_PATTERN)
                        begin
                            cmd_valid = 1'b1;
                            cmd_index = sdsi_pkg::CMD_IF_COND;
                            cmd_arg   = sdsi_pkg::ARG_IF_COND;
                            cmd_crc   = sdsi_pkg::CRC_CMD8;
                        end
                        else if (item.resp_tail[11:8] != sdsi_pkg::R7_VHS_OK)
                        begin
                            kind_next = sdsi_pkg::KIND_UNUSABLE;
                            step_next = sdsi_pkg::S_FAIL_R7;
                            status    = sdsi_pkg::STAT_BAD_R7;
                        end
                        else
                        begin
                            cmd_valid = 1'b1;
                            cmd_index = sdsi_pkg::CMD_READ_OCR;
                            cmd_crc   = sdsi_pkg::CRC_NONE;
                            step_next = sdsi_pkg::S_OCR1;
                        end
                    end
                    sdsi_pkg::S_OCR1:
                    begin
                        if (item.resp_r1 != sdsi_pkg::R1_IDLE)
                        begin
                            cmd_valid = 1'b1;
                            cmd_index = sdsi_pkg::CMD_READ_OCR;
                            cmd_crc   = sdsi_pkg::CRC_NONE;
                        end
                        else if (item.resp_tail[21:20] != 2'b11)
                        begin
                            kind_next = sdsi_pkg::KIND_UNUSABLE;
                            step_next = sdsi_pkg::S_FAIL_OCR;
                            status    = sdsi_pkg::STAT_BAD_OCR;
                        end
                        else
                        begin
                            cmd_valid = 1'b1;
                            cmd_index = sdsi_pkg::CMD_APP;
                            cmd_crc   = sdsi_pkg::CRC_NONE;
                            step_next = sdsi_pkg::S_CMD55;
                        end
                    end
                    sdsi_pkg::S_CMD55:
                    begin
                        cmd_valid = 1'b1;
                        cmd_crc   = sdsi_pkg::CRC_NONE;
                        if (item.resp_r1 == sdsi_pkg::R1_IDLE)
                        begin
                            cmd_index = sdsi_pkg::CMD_OP_COND;
                            cmd_arg   = sdsi_pkg::ARG_HCS;
                            step_next = sdsi_pkg::S_ACMD41;
                        end
                        else
                        begin
                            cmd_index = sdsi_pkg::CMD_APP;
                        end
                    end
                    sdsi_pkg::S_ACMD41:
                    begin
                        cmd_valid = 1'b1;
                        cmd_crc   = sdsi_pkg::CRC_NONE;
                        if (item.resp_r1 == sdsi_pkg::R1_OK)
                        begin
                            cmd_index = sdsi_pkg::CMD_READ_OCR;
                            step_next = sdsi_pkg::S_OCR2;
                        end
                        else
                        begin
                            cmd_index = sdsi_pkg::CMD_APP;
                            step_next = sdsi_pkg::S_CMD55;
                        end
                    end
                    sdsi_pkg::S_OCR2:
                    begin
                        if (item.resp_r1 != sdsi_pkg::R1_OK)
                        begin
                            cmd_valid = 1'b1;
                            cmd_index = sdsi_pkg::CMD_READ_OCR;
                            cmd_crc   = sdsi_pkg::CRC_NONE;
                        end
                        else if (!item.resp_tail[31])
                        begin
                            kind_next = sdsi_pkg::KIND_UNUSABLE;
                            step_next = sdsi_pkg::S_FAIL_PWR;
                            status    = sdsi_pkg::STAT_NO_POWER;
                        end
                        else
                        begin
                            kind_next = item.resp_tail[30] ? sdsi_pkg::KIND_SDHC
                                                           : sdsi_pkg::KIND_SDSC;
                            cmd_valid = 1'b1;
                            cmd_index = sdsi_pkg::CMD_CRC_ON;
                            cmd_crc   = sdsi_pkg::CRC_NONE;
                            step_next = sdsi_pkg::S_CMD59;
                        end
                    end
                    sdsi_pkg::S_CMD59:
                    begin
                        cmd_valid = 1'b1;
                        cmd_crc   = sdsi_pkg::CRC_NONE;
                        if (item.resp_r1 == sdsi_pkg::R1_OK)
                        begin
                            cmd_index = sdsi_pkg::CMD_SET_BLEN;
                            cmd_arg   = sdsi_pkg::SECTOR_BYTES;
                            step_next = sdsi_pkg::S_CMD16;
                        end
                        else
                        begin
                            cmd_index = sdsi_pkg::CMD_CRC_ON;
                        end
                    end
                    sdsi_pkg::S_CMD16:
                    begin
                        if (item.resp_r1 == sdsi_pkg::R1_OK)
                        begin
                            step_next = sdsi_pkg::S_READY;
                            status    = sdsi_pkg::STAT_READY;
                        end
                        else
                        begin
                            cmd_valid = 1'b1;
                            cmd_index = sdsi_pkg::CMD_SET_BLEN;
                            cmd_arg   = sdsi_pkg::SECTOR_BYTES;
                            cmd_crc   = sdsi_pkg::CRC_NONE;
                        end
                    end
                    sdsi_pkg::S_ACCESS:
                    begin
                        step_next = sdsi_pkg::S_READY;
                        status    = (item.resp_r1 == sdsi_pkg::R1_OK)
                                    ? sdsi_pkg::STAT_ACC_OK : sdsi_pkg::STAT_CARD_ERR;
                    end
                    default:
                    begin
                        status = sdsi_pkg::standing(step_reg);
                    end
                endcase
            end
            sdsi_pkg::REQ_ACCESS:
            begin
                if (item.access_kind == sdsi_pkg::ACC_STOP)
                begin
                    acc_arg = '0;
                end
                else if (kind_reg == sdsi_pkg::KIND_SDSC)
                begin
                    acc_arg = item.sector << sdsi_pkg::SECTOR_SHIFT;
                end
                else
                begin
                    acc_arg = item.sector;
                end
                if (step_reg == sdsi_pkg::S_READY
                    && item.access_kind inside {[sdsi_pkg::ACC_RD_SINGLE:sdsi_pkg::ACC_STOP]}
                    && kind_reg inside {sdsi_pkg::KIND_SDSC, sdsi_pkg::KIND_SDHC})
                begin
                    cmd_valid = 1'b1;
                    cmd_index = sdsi_pkg::access_cmd(item.access_kind);
                    cmd_arg   = acc_arg;
                    cmd_crc   = sdsi_pkg::CRC_NONE;
                    step_next = sdsi_pkg::S_ACCESS;
                end
                else
                begin
                    status = sdsi_pkg::STAT_REFUSED;
                end
            end
            default:
            begin
                status = sdsi_pkg::standing(step_reg);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= sdsi_pkg::S_IDLE;
            kind_reg <= sdsi_pkg::KIND_UNKNOWN;
        end
        else if (advance)
        begin
            step_reg <= step_next;
            kind_reg <= kind_next;
        end
    end

    assign res.cmd_valid   = cmd_valid;
    assign res.wake_clocks = wake;
    assign res.cmd_index   = cmd_index;
    assign res.cmd_arg     = cmd_arg;
    assign res.cmd_crc     = cmd_crc;
    assign res.card_type   = kind_next;
    assign res.status      = status;

endmodule

`default_nettype wire

/* sv/sdsi_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module sdsi_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic        cmd_valid,
    input wire logic        wake_clocks,
    input wire logic [5:0]  cmd_index,
    input wire logic [31:0] cmd_arg,
    input wire logic [7:0]  cmd_crc,
    input wire logic [2:0]  card_type,
    input wire logic [2:0]  status
);

    // input side only backs up behind a held output word
    a_stall_needs_held_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("in_stall without a stalled output word");

    a_no_cmd_zero_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !cmd_valid) |->
        (!wake_clocks && cmd_index == 6'd0 && cmd_arg == 32'd0 && cmd_crc == 8'd0))
        else $error("frame fields nonzero without a command");

    a_wake_is_cmd0: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && wake_clocks) |->
        (cmd_valid && cmd_index == sdsi_pkg::CMD_GO_IDLE
         && cmd_crc == sdsi_pkg::CRC_CMD0
         && card_type == sdsi_pkg::KIND_UNKNOWN
         && status == sdsi_pkg::STAT_BUSY))
        else $error("wake clocks not paired with a fresh CMD0");

    a_cmd8_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && cmd_valid && cmd_index == sdsi_pkg::CMD_IF_COND) |->
        (cmd_arg == sdsi_pkg::ARG_IF_COND && cmd_crc == sdsi_pkg::CRC_CMD8))
        else $error("CMD8 frame malformed");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(cmd_arg) && $stable(status)))
        else $error("stalled output word changed");

endmodule

bind sd_spi_init_and_access_sequencer_unit sdsi_checker u_sdsi_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .cmd_valid   (cmd_valid),
    .wake_clocks (wake_clocks),
    .cmd_index   (cmd_index),
    .cmd_arg     (cmd_arg),
    .cmd_crc     (cmd_crc),
    .card_type   (card_type),
    .status      (status)
);

`default_nettype wire

/* bench/sd_cmd_frame_checker.sv */
`timescale 1ns / 1ps

module sd_cmd_frame_checker
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic [1:0]  req_type,
    input  wire logic [7:0]  resp_r1,
    input  wire logic [31:0] resp_tail,
    input  wire logic [2:0]  access_kind,
    input  wire logic [31:0] sector,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic        cmd_valid,
    input  wire logic        wake_clocks,
    input  wire logic [5:0]  cmd_index,
    input  wire logic [31:0] cmd_arg,
    input  wire logic [7:0]  cmd_crc,
    input  wire logic [2:0]  card_type,
    input  wire logic [2:0]  status,
    output int               fails,
    output int               waiting
);

    sdsi_pkg::step_t   phase;
    logic [2:0]        kind_q;
    sdsi_pkg::result_t frames[$];
    sdsi_pkg::result_t want;

    function automatic sdsi_pkg::result_t cmd_frame(input logic [5:0] idx,
                                                    input logic [31:0] arg,
                                                    input logic [7:0] crc);
        sdsi_pkg::result_t f;
        f = '0;
        f.cmd_valid = 1'b1;
        f.cmd_index = idx;
        f.cmd_arg   = arg;
        f.cmd_crc   = crc;
        return f;
    endfunction

    function automatic logic [2:0] held_status(input sdsi_pkg::step_t s);
        logic [2:0] st;
        case (s)
            sdsi_pkg::S_IDLE:     st = sdsi_pkg::STAT_REFUSED;
            sdsi_pkg::S_READY:    st = sdsi_pkg::STAT_READY;
            sdsi_pkg::S_FAIL_R7:  st = sdsi_pkg::STAT_BAD_R7;
            sdsi_pkg::S_FAIL_OCR: st = sdsi_pkg::STAT_BAD_OCR;
            sdsi_pkg::S_FAIL_PWR: st = sdsi_pkg::STAT_NO_POWER;
            default:              st = sdsi_pkg::STAT_BUSY;
        endcase
        return st;
    endfunction

    // advances the sequencer copy by one request word
    function automatic sdsi_pkg::result_t next_frame(input sdsi_pkg::item_t w);
        sdsi_pkg::result_t f;
        logic [2:0]        st;
        logic [31:0]       arg;
        f = '0;
        st = sdsi_pkg::STAT_BUSY;
        case (w.req_type)
            sdsi_pkg::REQ_START:
            begin
                kind_q = sdsi_pkg::KIND_UNKNOWN;
                f = cmd_frame(sdsi_pkg::CMD_GO_IDLE, '0, sdsi_pkg::CRC_CMD0);
                f.wake_clocks = 1'b1;
                phase = sdsi_pkg::S_CMD0;
            end
            sdsi_pkg::REQ_RESP:
            begin
                case (phase)
                    sdsi_pkg::S_CMD0:
                        if (w.resp_r1 == sdsi_pkg::R1_IDLE)
                        begin
                            f = cmd_frame(sdsi_pkg::CMD_IF_COND, sdsi_pkg::ARG_IF_COND,
                                          sdsi_pkg::CRC_CMD8);
                            phase = sdsi_pkg::S_CMD8;
                        end
                        else
                            f = cmd_frame(sdsi_pkg::CMD_GO_IDLE, '0, sdsi_pkg::CRC_CMD0);
                    sdsi_pkg::S_CMD8:
                        if (w.resp_r1[2])
                        begin
                            kind_q = sdsi_pkg::KIND_V1;
                            f = cmd_frame(sdsi_pkg::CMD_READ_OCR, '0, sdsi_pkg::CRC_NONE);
                            phase = sdsi_pkg::S_OCR1;
                        end
                        else if (w.resp_tail[7:0] != sdsi_pkg::R7_PATTERN)
                            f = cmd_frame(sdsi_pkg::CMD_IF_COND, sdsi_pkg::ARG_IF_COND,
                                          sdsi_pkg::CRC_CMD8);
                        else if (w.resp_tail[11:8] != sdsi_pkg::R7_VHS_OK)
                        begin
                            kind_q = sdsi_pkg::KIND_UNUSABLE;
                            phase = sdsi_pkg::S_FAIL_R7;
                            st = sdsi_pkg::STAT_BAD_R7;
                        end
                        else
                        begin
                            f = cmd_frame(sdsi_pkg::CMD_READ_OCR, '0, sdsi_pkg::CRC_NONE);
                            phase = sdsi_pkg::S_OCR1;
                        end
                    sdsi_pkg::S_OCR1:
                        if (w.resp_r1 != sdsi_pkg::R1_IDLE)
                            f = cmd_frame(sdsi_pkg::CMD_READ_OCR, '0, sdsi_pkg::CRC_NONE);
                        else if (w.resp_tail[21:20] != 2'b11)
                        begin
                            kind_q = sdsi_pkg::KIND_UNUSABLE;
                            phase = sdsi_pkg::S_FAIL_OCR;
                            st = sdsi_pkg::STAT_BAD_OCR;
                        end
                        else
                        begin
                            f = cmd_frame(sdsi_pkg::CMD_APP, '0, sdsi_pkg::CRC_NONE);
                            phase = sdsi_pkg::S_CMD55;
                        end
                    sdsi_pkg::S_CMD55:
                        if (w.resp_r1 == sdsi_pkg::R1_IDLE)
                        begin
                            f = cmd_frame(sdsi_pkg::CMD_OP_COND, sdsi_pkg::ARG_HCS,
                                          sdsi_pkg::CRC_NONE);
                            phase = sdsi_pkg::S_ACMD41;
                        end
                        else
                            f = cmd_frame(sdsi_pkg::CMD_APP, '0, sdsi_pkg::CRC_NONE);
                    sdsi_pkg::S_ACMD41:
                        if (w.resp_r1 == sdsi_pkg::R1_OK)
                        begin
                            f = cmd_frame(sdsi_pkg::CMD_READ_OCR, '0, sdsi_pkg::CRC_NONE);
                            phase = sdsi_pkg::S_OCR2;
                        end
                        else
                        begin
                            f = cmd_frame(sdsi_pkg::CMD_APP, '0, sdsi_pkg::CRC_NONE);
                            phase = sdsi_pkg::S_CMD55;
                        end
                    sdsi_pkg::S_OCR2:
                        if (w.resp_r1 != sdsi_pkg::R1_OK)
                            f = cmd_frame(sdsi_pkg::CMD_READ_OCR, '0, sdsi_pkg::CRC_NONE);
                        else if (!w.resp_tail[31])
                        begin
                            kind_q = sdsi_pkg::KIND_UNUSABLE;
                            phase = sdsi_pkg::S_FAIL_PWR;
                            st = sdsi_pkg::STAT_NO_POWER;
                        end
                        else
                        begin
                            kind_q = w.resp_tail[30] ? sdsi_pkg::KIND_SDHC
                                                     : sdsi_pkg::KIND_SDSC;
                            f = cmd_frame(sdsi_pkg::CMD_CRC_ON, '0, sdsi_pkg::CRC_NONE);
                            phase = sdsi_pkg::S_CMD59;
                        end
                    sdsi_pkg::S_CMD59:
                        if (w.resp_r1 == sdsi_pkg::R1_OK)
                        begin
                            f = cmd_frame(sdsi_pkg::CMD_SET_BLEN, sdsi_pkg::SECTOR_BYTES,
                                          sdsi_pkg::CRC_NONE);
                            phase = sdsi_pkg::S_CMD16;
                        end
                        else
                            f = cmd_frame(sdsi_pkg::CMD_CRC_ON, '0, sdsi_pkg::CRC_NONE);
                    sdsi_pkg::S_CMD16:
                        if (w.resp_r1 == sdsi_pkg::R1_OK)
                        begin
                            phase = sdsi_pkg::S_READY;
                            st = sdsi_pkg::STAT_READY;
                        end
                        else
                            f = cmd_frame(sdsi_pkg::CMD_SET_BLEN, sdsi_pkg::SECTOR_BYTES,
                                          sdsi_pkg::CRC_NONE);
                    sdsi_pkg::S_ACCESS:
                    begin
                        phase = sdsi_pkg::S_READY;
                        st = (w.resp_r1 == sdsi_pkg::R1_OK) ? sdsi_pkg::STAT_ACC_OK
                                                            : sdsi_pkg::STAT_CARD_ERR;
                    end
                    default:
                        st = held_status(phase);
                endcase
            end
            sdsi_pkg::REQ_ACCESS:
            begin
                if (phase != sdsi_pkg::S_READY || w.access_kind > sdsi_pkg::ACC_STOP
                    || !(kind_q == sdsi_pkg::KIND_SDSC || kind_q == sdsi_pkg::KIND_SDHC))
                    st = sdsi_pkg::STAT_REFUSED;
                else
                begin
                    arg = (kind_q == sdsi_pkg::KIND_SDSC)
                          ? (w.sector << sdsi_pkg::SECTOR_SHIFT) : w.sector;
                    case (w.access_kind)
                        sdsi_pkg::ACC_RD_SINGLE:
                            f = cmd_frame(sdsi_pkg::CMD_RD_SINGLE, arg, sdsi_pkg::CRC_NONE);
                        sdsi_pkg::ACC_RD_MULTI:
                            f = cmd_frame(sdsi_pkg::CMD_RD_MULTI, arg, sdsi_pkg::CRC_NONE);
                        sdsi_pkg::ACC_WR_SINGLE:
                            f = cmd_frame(sdsi_pkg::CMD_WR_SINGLE, arg, sdsi_pkg::CRC_NONE);
                        sdsi_pkg::ACC_WR_MULTI:
                            f = cmd_frame(sdsi_pkg::CMD_WR_MULTI, arg, sdsi_pkg::CRC_NONE);
                        default:
                            f = cmd_frame(sdsi_pkg::CMD_STOP, '0, sdsi_pkg::CRC_NONE);
                    endcase
                    phase = sdsi_pkg::S_ACCESS;
                end
            end
            default:
                st = held_status(phase);
        endcase
        f.card_type = kind_q;
        f.status    = st;
        return f;
    endfunction

    task automatic report(input string field, input logic [31:0] got, input logic [31:0] exp_v);
        fails++;
        $display("%0t mismatch %s: got 'h%0h, expected 'h%0h", $realtime, field, got, exp_v);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase = sdsi_pkg::S_IDLE;
            kind_q = sdsi_pkg::KIND_UNKNOWN;
            frames.delete();
            fails = 0;
            waiting = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (frames.size() == 0)
                    report("word with nothing expected", 32'(out_valid), 32'd0);
                else
                begin
                    want = frames.pop_front();
                    if (cmd_valid !== want.cmd_valid)
                        report("cmd_valid", 32'(cmd_valid), 32'(want.cmd_valid));
                    if (wake_clocks !== want.wake_clocks)
                        report("wake_clocks", 32'(wake_clocks), 32'(want.wake_clocks));
                    if (cmd_index !== want.cmd_index)
                        report("cmd_index", 32'(cmd_index), 32'(want.cmd_index));
                    if (cmd_arg !== want.cmd_arg)
                        report("cmd_arg", cmd_arg, want.cmd_arg);
                    if (cmd_crc !== want.cmd_crc)
                        report("cmd_crc", 32'(cmd_crc), 32'(want.cmd_crc));
                    if (card_type !== want.card_type)
                        report("card_type", 32'(card_type), 32'(want.card_type));
                    if (status !== want.status)
                        report("status", 32'(status), 32'(want.status));
                end
            end
            if (in_valid && !in_stall)
                frames.push_back(next_frame({req_type, resp_r1, resp_tail, access_kind, sector}));
            waiting = frames.size();
        end
    end

endmodule

/* bench/tb_sd_spi_init_and_access_sequencer_unit.sv */
`timescale 1ns / 1ps

module tb_sd_spi_init_and_access_sequencer_unit;

    localparam int         WORD_TARGET = 450;
    localparam int         CYCLE_LIMIT = 200000;
    localparam logic [1:0] REQ_NONE    = 2'd3;
    localparam logic [2:0] ACC_BAD     = 3'd7;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic [1:0]  req_type = '0;
    logic [7:0]  resp_r1 = '0;
    logic [31:0] resp_tail = '0;
    logic [2:0]  access_kind = '0;
    logic [31:0] sector = '0;
    logic        out_stall = 1'b0;

    logic        in_stall;
    logic        out_valid;
    logic        cmd_valid;
    logic        wake_clocks;
    logic [5:0]  cmd_index;
    logic [31:0] cmd_arg;
    logic [7:0]  cmd_crc;
    logic [2:0]  card_type;
    logic [2:0]  status;

    int   fails;
    int   waiting;
    logic taken;
    int   burst_left = 0;
    int   sent = 0;

    always #1 clk = ~clk;

    sd_spi_init_and_access_sequencer_unit u_top
    (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .req_type(req_type),
        .resp_r1(resp_r1),
        .resp_tail(resp_tail),
        .access_kind(access_kind),
        .sector(sector),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .cmd_valid(cmd_valid),
        .wake_clocks(wake_clocks),
        .cmd_index(cmd_index),
        .cmd_arg(cmd_arg),
        .cmd_crc(cmd_crc),
        .card_type(card_type),
        .status(status)
    );

    sd_cmd_frame_checker u_checker
    (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .req_type(req_type),
        .resp_r1(resp_r1),
        .resp_tail(resp_tail),
        .access_kind(access_kind),
        .sector(sector),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .cmd_valid(cmd_valid),
        .wake_clocks(wake_clocks),
        .cmd_index(cmd_index),
        .cmd_arg(cmd_arg),
        .cmd_crc(cmd_crc),
        .card_type(card_type),
        .status(status),
        .fails(fails),
        .waiting(waiting)
    );

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            taken <= 1'b0;
        else
            taken <= in_valid && !in_stall;
    end

    // one request word, sent in bursts with random gaps
    task automatic put(input logic [1:0] rq, input logic [7:0] r1, input logic [31:0] tl,
                       input logic [2:0] ak, input logic [31:0] sec);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        if (rq != REQ_NONE)
            sent++;
        in_valid    <= 1'b1;
        req_type    <= rq;
        resp_r1     <= r1;
        resp_tail   <= tl;
        access_kind <= ak;
        sector      <= sec;
        @(negedge clk);
        while (!taken)
            @(negedge clk);
    endtask

    function automatic logic [7:0] other_than(input logic [7:0] v);
        logic [7:0] b;
        b = 8'($urandom);
        if (b == v)
            b = ~v;
        return b;
    endfunction

    task automatic resp(input logic [7:0] r1, input logic [31:0] tl);
        put(sdsi_pkg::REQ_RESP, r1, tl, 3'($urandom), $urandom);
    endtask

    task automatic after_failure();
        put(sdsi_pkg::REQ_ACCESS, 8'($urandom), $urandom, 3'($urandom_range(0, 4)), $urandom);
        resp(8'($urandom), $urandom);
        put(REQ_NONE, 8'($urandom), $urandom, 3'($urandom), $urandom);
    endtask

    // well-formed card session with random content, sometimes cut short
    task automatic run_session();
        int          stage;
        int          cut;
        logic [31:0] tl;
        logic [2:0]  ak;
        stage = 0;
        cut = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 6) : 0;
        put(sdsi_pkg::REQ_START, 8'($urandom), $urandom, 3'($urandom), $urandom);
        repeat ($urandom_range(0, 2)) resp(other_than(sdsi_pkg::R1_IDLE), $urandom);
        resp(sdsi_pkg::R1_IDLE, $urandom);
        stage++;
        if (stage == cut) return;

        if ($urandom_range(0, 3) == 0)
            resp(8'($urandom) | 8'h04, $urandom);
        else
        begin
            repeat ($urandom_range(0, 2))
            begin
                tl = $urandom;
                if (tl[7:0] == sdsi_pkg::R7_PATTERN)
                    tl[0] = ~tl[0];
                resp(8'($urandom) & 8'hFB, tl);
            end
            tl = $urandom;
            tl[7:0] = sdsi_pkg::R7_PATTERN;
            tl[11:8] = sdsi_pkg::R7_VHS_OK;
            if ($urandom_range(0, 7) == 0)
                tl[11:8] = ~sdsi_pkg::R7_VHS_OK ^ 4'($urandom_range(0, 13));
            resp(8'($urandom) & 8'hFB, tl);
            if (tl[11:8] != sdsi_pkg::R7_VHS_OK)
            begin
                after_failure();
                return;
            end
        end
        stage++;
        if (stage == cut) return;

        repeat ($urandom_range(0, 2)) resp(other_than(sdsi_pkg::R1_IDLE), $urandom);
        tl = $urandom;
        tl[21:20] = ($urandom_range(0, 7) == 0) ? 2'($urandom_range(0, 2)) : 2'b11;
        resp(sdsi_pkg::R1_IDLE, tl);
        if (tl[21:20] != 2'b11)
        begin
            after_failure();
            return;
        end
        stage++;
        if (stage == cut) return;

        repeat ($urandom_range(0, 3))
        begin
            repeat ($urandom_range(0, 1)) resp(other_than(sdsi_pkg::R1_IDLE), $urandom);
            resp(sdsi_pkg::R1_IDLE, $urandom);
            resp(other_than(sdsi_pkg::R1_OK), $urandom);
        end
        repeat ($urandom_range(0, 1)) resp(other_than(sdsi_pkg::R1_IDLE), $urandom);
        resp(sdsi_pkg::R1_IDLE, $urandom);
        resp(sdsi_pkg::R1_OK, $urandom);
        stage++;
        if (stage == cut) return;

        repeat ($urandom_range(0, 2)) resp(other_than(sdsi_pkg::R1_OK), $urandom);
        tl = $urandom;
        tl[31] = ($urandom_range(0, 7) != 0);
        resp(sdsi_pkg::R1_OK, tl);
        if (!tl[31])
        begin
            after_failure();
            return;
        end
        stage++;
        if (stage == cut) return;

        repeat ($urandom_range(0, 2)) resp(other_than(sdsi_pkg::R1_OK), $urandom);
        resp(sdsi_pkg::R1_OK, $urandom);
        repeat ($urandom_range(0, 2)) resp(other_than(sdsi_pkg::R1_OK), $urandom);
        resp(sdsi_pkg::R1_OK, $urandom);
        stage++;
        if (stage == cut) return;

        repeat ($urandom_range(1, 10))
        begin
            ak = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(5, 7))
                                             : 3'($urandom_range(0, 4));
            put(sdsi_pkg::REQ_ACCESS, 8'($urandom), $urandom, ak, $urandom);
            if (ak <= sdsi_pkg::ACC_STOP)
            begin
                if ($urandom_range(0, 9) == 0)
                    put(sdsi_pkg::REQ_ACCESS, 8'($urandom), $urandom, 3'($urandom), $urandom);
                resp(($urandom_range(0, 3) == 0) ? 8'($urandom) : sdsi_pkg::R1_OK, $urandom);
            end
            else if ($urandom_range(0, 3) == 0)
                resp(8'($urandom), $urandom);
        end
    endtask

    initial
    begin : receiver
        int tick;
        int mode;
        tick = 0;
        mode = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            tick++;
            if (tick >= 400 && tick < 520)
                out_stall <= 1'b1;
            else
            begin
                if (tick % 64 == 0)
                    mode = $urandom_range(0, 3);
                case (mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= 1'($urandom_range(0, 1));
                    2:       out_stall <= (tick % 3 == 0);
                    default: out_stall <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    initial
    begin : watchdog
        int cycles;
        for (cycles = 0; cycles < CYCLE_LIMIT; cycles++)
            @(posedge clk);
        $display("tb_sd_spi_init_and_access_sequencer_unit NOT OK");
        $finish;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        resp(sdsi_pkg::R1_OK, $urandom);
        put(sdsi_pkg::REQ_ACCESS, 8'($urandom), $urandom, sdsi_pkg::ACC_RD_SINGLE, $urandom);
        put(REQ_NONE, 8'($urandom), $urandom, 3'($urandom), $urandom);
        put(sdsi_pkg::REQ_START, 8'($urandom), $urandom, 3'($urandom), $urandom);
        resp(8'hFF, 32'hFFFF_FFFF);
        resp(sdsi_pkg::R1_IDLE, 32'h0000_0000);
        resp(8'h05, 32'h0000_01AA);
        resp(sdsi_pkg::R1_IDLE, 32'h0030_0000);
        put(sdsi_pkg::REQ_ACCESS, 8'($urandom), $urandom, sdsi_pkg::ACC_WR_SINGLE, $urandom);
        resp(sdsi_pkg::R1_IDLE, $urandom);
        resp(sdsi_pkg::R1_IDLE, $urandom);
        resp(sdsi_pkg::R1_IDLE, $urandom);
        resp(sdsi_pkg::R1_OK, $urandom);
        resp(sdsi_pkg::R1_OK, 32'h8000_0000);
        resp(sdsi_pkg::R1_OK, $urandom);
        resp(sdsi_pkg::R1_OK, $urandom);
        put(sdsi_pkg::REQ_ACCESS, 8'($urandom), $urandom, sdsi_pkg::ACC_RD_SINGLE,
            32'hFFFF_FFFF);
        resp(sdsi_pkg::R1_OK, $urandom);
        put(sdsi_pkg::REQ_ACCESS, 8'($urandom), $urandom, sdsi_pkg::ACC_WR_MULTI,
            32'h0012_3456);
        resp(8'h80, $urandom);
        put(sdsi_pkg::REQ_ACCESS, 8'($urandom), $urandom, ACC_BAD, $urandom);
        put(sdsi_pkg::REQ_ACCESS, 8'($urandom), $urandom, sdsi_pkg::ACC_STOP, 32'hFFFF_FFFF);
        resp(sdsi_pkg::R1_OK, $urandom);
        resp(sdsi_pkg::R1_OK, $urandom);
        put(sdsi_pkg::REQ_START, 8'($urandom), $urandom, 3'($urandom), $urandom);

        while (sent < WORD_TARGET)
        begin
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 4))
                    put(2'($urandom_range(0, 3)), 8'($urandom), $urandom, 3'($urandom),
                        $urandom);
            run_session();
        end

        in_valid <= 1'b0;
        while (waiting != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        if (fails == 0)
            $display("tb_sd_spi_init_and_access_sequencer_unit OK");
        else
            $display("tb_sd_spi_init_and_access_sequencer_unit NOT OK");
        $finish;
    end

endmodule
